// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CHK_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CHK_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

// next-cycle implication, always active
`define CHK_NEXT_ANY(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/atau_pkg.sv =====
// constants and types for the tilt angle unit
package atau_pkg;

    localparam int IN_W       = 16;
    localparam int OUT_W      = 15;
    localparam int SQ_W       = 32;
    localparam int ROOT_W     = 32;
    localparam int REM_W      = 35;
    localparam int SQRT_STEPS = 32;
    localparam int CRD_W      = 36;
    localparam int ANG_W      = 32;
    localparam int TABLE_BITS = 24;
    localparam int TABLE_LEN  = 24;

    typedef logic [1:0] t_spec;
    localparam t_spec SPEC_NONE = 2'd0;
    localparam t_spec SPEC_POS  = 2'd1;
    localparam t_spec SPEC_NEG  = 2'd2;
    localparam t_spec SPEC_ZERO = 2'd3;

    // atan(2^-i) in degrees, 24 fraction bits
    localparam logic [ANG_W-1:0] ATAN_TAB [0:TABLE_LEN-1] = '{
        32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
        32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
        32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
        32'd234684,    32'd117342,    32'd58671,     32'd29335,
        32'd14668,     32'd7334,      32'd3667,      32'd1833,
        32'd917,       32'd458,       32'd229,       32'd115
    };

endpackage

// ===== rtl/accelerometer_tilt_angles_unit.sv =====
// tilt angle unit: three atan angles from one accelerometer sample
// pipelined, one stage per root bit and cordic step
// throughput: one sample per cycle, whole pipeline holds while a result waits under stall
// reset: synchronous active low, clears the valid bits only
module accelerometer_tilt_angles_unit #(
    parameter int ANGLE_FRACTION_BITS = 7,
    parameter int CORDIC_STEPS        = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [atau_pkg::IN_W-1:0]    i_accel_x,
    input  logic signed [atau_pkg::IN_W-1:0]    i_accel_y,
    input  logic signed [atau_pkg::IN_W-1:0]    i_accel_z,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [atau_pkg::OUT_W-1:0]   o_angle_x,
    output logic signed [atau_pkg::OUT_W-1:0]   o_angle_y,
    output logic signed [atau_pkg::OUT_W-1:0]   o_angle_z
);
    import atau_pkg::*;

    localparam int LAT = SQRT_STEPS + CORDIC_STEPS + 4;

    logic           en;
    logic [LAT-1:0] r_vld;

    assign en      = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    atau_lane #(
        .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS),
        .CORDIC_STEPS       (CORDIC_STEPS)
    ) u_lane_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (i_accel_x),
        .i_p    (i_accel_y),
        .i_q    (i_accel_z),
        .o_angle(o_angle_x)
    );

    atau_lane #(
        .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS),
        .CORDIC_STEPS       (CORDIC_STEPS)
    ) u_lane_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (i_accel_y),
        .i_p    (i_accel_x),
        .i_q    (i_accel_z),
        .o_angle(o_angle_y)
    );

    atau_lane #(
        .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS),
        .CORDIC_STEPS       (CORDIC_STEPS)
    ) u_lane_z (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (i_accel_z),
        .i_p    (i_accel_x),
        .i_q    (i_accel_y),
        .o_angle(o_angle_z)
    );

endmodule

// ===== rtl/atau_lane.sv =====
// one angle lane: squares, pipelined integer root, vectoring cordic, rounding, saturation
module atau_lane #(
    parameter int ANGLE_FRACTION_BITS = 7,
    parameter int CORDIC_STEPS        = 16
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [atau_pkg::IN_W-1:0]    i_num,
    input  logic signed [atau_pkg::IN_W-1:0]    i_p,
    input  logic signed [atau_pkg::IN_W-1:0]    i_q,
    output logic        [atau_pkg::OUT_W-1:0]   o_angle
);
    import atau_pkg::*;

    localparam int SH = TABLE_BITS - ANGLE_FRACTION_BITS;
    localparam logic [ANG_W-1:0] HALF = ANG_W'(1) << (SH - 1);
    localparam logic [ANG_W-1:0] LIM  = ANG_W'(90) << ANGLE_FRACTION_BITS;

    function automatic logic signed [CRD_W-1:0] shr_trunc(
        input logic signed [CRD_W-1:0] v,
        input int unsigned             s
    );
        logic [CRD_W-1:0] mag;
        mag = v[CRD_W-1] ? CRD_W'(-v) : CRD_W'(v);
        mag = mag >> s;
        return v[CRD_W-1] ? -$signed(mag) : $signed(mag);
    endfunction

    logic signed [IN_W-1:0] r1_num;
    logic [SQ_W-1:0]        r1_pp;
    logic [SQ_W-1:0]        r1_qq;
    logic signed [2*IN_W-1:0] n_pp;
    logic signed [2*IN_W-1:0] n_qq;

    assign n_pp = i_p * i_p;
    assign n_qq = i_q * i_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_num <= i_num;
            r1_pp  <= SQ_W'(n_pp);
            r1_qq  <= SQ_W'(n_qq);
        end
    end

    // sum of squares and special cases
    logic [SQ_W-1:0]        r2_s;
    logic signed [IN_W-1:0] r2_num;
    t_spec                  r2_spec;
    t_spec                  n_spec;

    always_comb begin
        if (r1_pp == '0 && r1_qq == '0) begin
            if (r1_num == '0)        n_spec = SPEC_ZERO;
            else if (r1_num[IN_W-1]) n_spec = SPEC_NEG;
            else                     n_spec = SPEC_POS;
        end else if (r1_num == '0) begin
            n_spec = SPEC_ZERO;
        end else begin
            n_spec = SPEC_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_s    <= r1_pp + r1_qq;
            r2_num  <= r1_num;
            r2_spec <= n_spec;
        end
    end

    // root of s * 2^32, one result bit per stage
    logic [REM_W-1:0]       r_rem  [0:SQRT_STEPS];
    logic [ROOT_W-1:0]      r_root [0:SQRT_STEPS];
    logic [SQ_W-1:0]        r_sv   [0:SQRT_STEPS];
    logic signed [IN_W-1:0] r_snum [0:SQRT_STEPS];
    t_spec                  r_sspec[0:SQRT_STEPS];

    assign r_rem[0]   = '0;
    assign r_root[0]  = '0;
    assign r_sv[0]    = r2_s;
    assign r_snum[0]  = r2_num;
    assign r_sspec[0] = r2_spec;

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        logic [REM_W-1:0] n_rem;
        logic [REM_W-1:0] n_trial;
        assign n_rem   = {r_rem[j][REM_W-3:0], r_sv[j][SQ_W-1 -: 2]};
        assign n_trial = {1'b0, r_root[j], 2'b01};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (n_rem >= n_trial) begin
                    r_rem[j+1]  <= n_rem - n_trial;
                    r_root[j+1] <= {r_root[j][ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[j+1]  <= n_rem;
                    r_root[j+1] <= {r_root[j][ROOT_W-2:0], 1'b0};
                end
                r_sv[j+1]    <= {r_sv[j][SQ_W-3:0], 2'b00};
                r_snum[j+1]  <= r_snum[j];
                r_sspec[j+1] <= r_sspec[j];
            end
        end
    end

    // vectoring cordic
    logic signed [CRD_W-1:0] r_cx   [0:CORDIC_STEPS];
    logic signed [CRD_W-1:0] r_cy   [0:CORDIC_STEPS];
    logic signed [ANG_W-1:0] r_cz   [0:CORDIC_STEPS];
    t_spec                   r_cspec[0:CORDIC_STEPS];

    assign r_cx[0]    = $signed({{(CRD_W-ROOT_W){1'b0}}, r_root[SQRT_STEPS]});
    assign r_cy[0]    = $signed({{(CRD_W-IN_W-16){r_snum[SQRT_STEPS][IN_W-1]}},
                                 r_snum[SQRT_STEPS], 16'b0});
    assign r_cz[0]    = '0;
    assign r_cspec[0] = r_sspec[SQRT_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        logic signed [CRD_W-1:0] n_dx;
        logic signed [CRD_W-1:0] n_dy;
        assign n_dx = shr_trunc(r_cy[i], i);
        assign n_dy = shr_trunc(r_cx[i], i);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_cy[i][CRD_W-1]) begin
                    r_cx[i+1] <= r_cx[i] + n_dx;
                    r_cy[i+1] <= r_cy[i] - n_dy;
                    r_cz[i+1] <= r_cz[i] + $signed(ATAN_TAB[i]);
                end else begin
                    r_cx[i+1] <= r_cx[i] - n_dx;
                    r_cy[i+1] <= r_cy[i] + n_dy;
                    r_cz[i+1] <= r_cz[i] - $signed(ATAN_TAB[i]);
                end
                r_cspec[i+1] <= r_cspec[i];
            end
        end
    end

    // rounding, half away from zero
    logic [ANG_W-1:0] r_rnd;
    logic             r_neg;
    t_spec            r_rspec;
    logic [ANG_W-1:0] n_mag;
    logic [ANG_W-1:0] n_sum;

    assign n_mag = r_cz[CORDIC_STEPS][ANG_W-1] ? ANG_W'(-r_cz[CORDIC_STEPS])
                                               : ANG_W'(r_cz[CORDIC_STEPS]);
    assign n_sum = n_mag + HALF;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rnd   <= n_sum >> SH;
            r_neg   <= r_cz[CORDIC_STEPS][ANG_W-1];
            r_rspec <= r_cspec[CORDIC_STEPS];
        end
    end

    // saturation and special results
    logic [ANG_W-1:0] n_sat;
    logic [ANG_W-1:0] n_res;
    logic [OUT_W-1:0] r_out;

    assign n_sat = (r_rnd > LIM) ? LIM : r_rnd;

    always_comb begin
        unique case (r_rspec)
            SPEC_POS:  n_res = LIM;
            SPEC_NEG:  n_res = -LIM;
            SPEC_ZERO: n_res = '0;
            default:   n_res = r_neg ? -n_sat : n_sat;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_res[OUT_W-1:0];
        end
    end

    assign o_angle = r_out;

endmodule

// ===== rtl/atau_chk.sv =====
// port checker for the tilt angle unit and its bind
`include "assert_macros.svh"

module atau_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_stall,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic signed [atau_pkg::OUT_W-1:0]   o_angle_x,
    input logic signed [atau_pkg::OUT_W-1:0]   o_angle_y,
    input logic signed [atau_pkg::OUT_W-1:0]   o_angle_z
);

    `CHK_SAME(a_stall_only_on_held_result, 1'b1, o_stall == (o_valid && i_stall), "bad stall")
    `CHK_NEXT(a_held_result_stays, o_valid && i_stall, o_valid, "result dropped under stall")
    `CHK_NEXT(a_held_payload_stable, o_valid && i_stall, $stable({o_angle_x, o_angle_y, o_angle_z}), "payload moved")
    `CHK_NEXT_ANY(a_reset_clears_valid, !i_rst_n, !o_valid, "valid after reset")

endmodule

bind accelerometer_tilt_angles_unit atau_chk u_atau_chk (.*);
